FILE: src/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Types, constants and state codes shared by the vertex normal averaging unit.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int VERTEX_SLOTS = 1024;
  localparam int IDX_W        = $clog2(VERTEX_SLOTS);
  localparam int MAX_FACES    = 255;
  localparam int TALLY_W      = 8;
  localparam int POS_W        = 32;
  localparam int SUM_W        = 24;
  localparam int NRM_W        = 16;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FACE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_FACE,
    KIND_READ
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    logic [IDX_W-1:0]        ca;
    logic [IDX_W-1:0]        cb;
    logic [IDX_W-1:0]        cc;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
  } pos_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic [TALLY_W-1:0]      tally;
    logic                    ovf;
  } stat_t;

  // divider request: partial remainder, divisor, low dividend bits, step count
  typedef struct packed {
    logic [31:0] rem_init;
    logic [31:0] den;
    logic [23:0] low;
    logic [4:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic take;
    logic clearing;
  } bk_stat_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STAT_RD,
    ST_POS_B,
    ST_POS_A,
    ST_POS_C,
    ST_SCALE,
    ST_CROSS,
    ST_NORM_CHK,
    ST_NORM,
    ST_SQ,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_OUT
  } bk_state_t;

endpackage

FILE: src/vna_in_if.sv
// ----------------------------------------------------------------------------
// vna_in_if
// Input channel: one vertex load, face or read word per handshake.
// ----------------------------------------------------------------------------
interface vna_in_if import vna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [IDX_W-1:0]        corner_a;
  logic [IDX_W-1:0]        corner_b;
  logic [IDX_W-1:0]        corner_c;

  modport source (output valid, mode, vertex_index, pos_x, pos_y, pos_z,
                  corner_a, corner_b, corner_c, input ready);
  modport sink (input valid, mode, vertex_index, pos_x, pos_y, pos_z,
                corner_a, corner_b, corner_c, output ready);
endinterface

FILE: src/vna_out_if.sv
// ----------------------------------------------------------------------------
// vna_out_if
// Result channel: one averaged vertex normal word per handshake.
// ----------------------------------------------------------------------------
interface vna_out_if import vna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        read_index;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic [TALLY_W-1:0]      touching_faces;
  logic                    no_faces;
  logic                    count_saturated;

  modport source (output valid, read_index, normal_x, normal_y, normal_z,
                  touching_faces, no_faces, count_saturated, input ready);
  modport sink (input valid, read_index, normal_x, normal_y, normal_z,
                touching_faces, no_faces, count_saturated, output ready);
endinterface

FILE: src/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front
// Accepts input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  vna_in_if.sink   in_ch,
  input  bk_stat_t bk_stat,
  output logic     q_valid,
  output item_t    q_item
);

  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push, pop, known;
  item_t             cls;

  assign in_ch.ready = (count_r != QDEPTH[QPTR_W:0]) && !bk_stat.clearing;
  assign q_valid     = (count_r != '0);
  assign q_item      = q_mem_r[rd_ptr_r];
  assign pop         = q_valid && bk_stat.take;

  always_comb begin
    known    = 1'b1;
    cls.idx  = in_ch.vertex_index;
    cls.px   = in_ch.pos_x;
    cls.py   = in_ch.pos_y;
    cls.pz   = in_ch.pos_z;
    cls.ca   = in_ch.corner_a;
    cls.cb   = in_ch.corner_b;
    cls.cc   = in_ch.corner_c;
    case (in_ch.mode)
      MODE_LOAD: cls.kind = KIND_LOAD;
      MODE_FACE: cls.kind = KIND_FACE;
      MODE_READ: cls.kind = KIND_READ;
      default: begin
        // drop the undefined mode here
        cls.kind = KIND_LOAD;
        known    = 1'b0;
      end
    endcase
  end

  assign push = in_ch.valid && in_ch.ready && known;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QDEPTH[QPTR_W:0])
    else $error("queue count beyond depth");

  a_no_push_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> !push)
    else $error("word queued during clearing sweep");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

FILE: src/vna_div.sv
// ----------------------------------------------------------------------------
// vna_div
// Restoring divider, one quotient bit per cycle, shared by face and read work.
// ----------------------------------------------------------------------------
module vna_div import vna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  div_req_t    req,
  output logic        done,
  output logic [23:0] quo
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [23:0] low_r, low_nxt;
  logic [23:0] quo_r, quo_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] trial;

  assign done = done_r;
  assign quo  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    trial    = {rem_r, low_r[23]};
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = req.rem_init;
      den_nxt  = req.den;
      low_nxt  = req.low;
      quo_nxt  = '0;
      cnt_nxt  = req.steps;
    end else if (busy_r) begin
      low_nxt = {low_r[22:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = 32'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[22:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

endmodule

FILE: src/vna_isqrt.sv
// ----------------------------------------------------------------------------
// vna_isqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vna_isqrt import vna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] n_in,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] n_r, n_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [63:0] trial;

  assign done = done_r;
  assign root = r_r[31:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    n_nxt    = n_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    trial    = r_r + bit_r;
    if (start) begin
      busy_nxt = 1'b1;
      n_nxt    = n_in;
      r_nxt    = '0;
      bit_nxt  = 64'd1 << 62;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_nxt = n_r - trial;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

endmodule

FILE: src/vna_back.sv
// ----------------------------------------------------------------------------
// vna_back
// Sequencer that carries out load, face and read words against the vertex
// position and normal-sum memories.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output bk_stat_t    bk_stat,
  vna_out_if.source   out_ch,
  output logic        div_start,
  output div_req_t    div_req,
  input  logic        div_done,
  input  logic [23:0] div_quo,
  output logic        sqrt_start,
  output logic [63:0] sqrt_n,
  input  logic        sqrt_done,
  input  logic [31:0] sqrt_root
);

  function automatic logic [62:0] mag63(input logic signed [62:0] v);
    mag63 = v[62] ? 63'(-v) : 63'(v);
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic signed [SUM_W-1:0] add_clamp(
    input logic signed [SUM_W-1:0] s, input logic signed [NRM_W-1:0] n);
    logic signed [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W-NRM_W+1){n[NRM_W-1]}}, n};
    if (t[SUM_W] != t[SUM_W-1]) begin
      add_clamp = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      add_clamp = t[SUM_W-1:0];
    end
  endfunction

  pos_t  pos_mem  [VERTEX_SLOTS];
  stat_t stat_mem [VERTEX_SLOTS];
  pos_t  pos_q;
  stat_t stat_q;

  bk_state_t               state_r, state_nxt;
  logic [2:0]              cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        clr_r, clr_nxt;
  item_t                   item_r, item_nxt;
  pos_t                    pb_r, pb_nxt, pa_r, pa_nxt;
  logic signed [32:0]      e_r [6];
  logic signed [32:0]      e_nxt [6];
  logic signed [65:0]      mul_p_r, mul_p_nxt;
  logic signed [62:0]      cr_r [3];
  logic signed [62:0]      cr_nxt [3];
  logic [62:0]             u_r, u_nxt;
  logic [63:0]             sq_r, sq_nxt;
  logic [31:0]             len_r, len_nxt;
  logic signed [NRM_W-1:0] nrm_r [3];
  logic signed [NRM_W-1:0] nrm_nxt [3];
  stat_t                   st_r, st_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic signed [NRM_W-1:0] out_nx_r, out_nx_nxt;
  logic signed [NRM_W-1:0] out_ny_r, out_ny_nxt;
  logic signed [NRM_W-1:0] out_nz_r, out_nz_nxt;
  logic [TALLY_W-1:0]      out_tally_r, out_tally_nxt;
  logic                    out_none_r, out_none_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic                    pos_we, stat_we;
  logic [IDX_W-1:0]        pos_waddr, pos_raddr, stat_waddr, stat_raddr;
  pos_t                    pos_wdata;
  stat_t                   stat_wdata;
  logic signed [32:0]      mul_a, mul_b;

  logic [1:0]              ci;
  logic [1:0]              pj;
  logic [32:0]             emag [6];
  logic                    any31, any30;
  logic [62:0]             cmag_full;
  logic [31:0]             cmag;
  logic [45:0]             fnum;
  logic signed [SUM_W-1:0] rsum;
  logic [SUM_W-1:0]        rmag;
  logic [SUM_W-1:0]        rnum;
  logic                    neg;
  logic [NRM_W-1:0]        q16;
  logic [IDX_W-1:0]        corner;

  assign bk_stat.take     = (state_r == ST_IDLE);
  assign bk_stat.clearing = (state_r == ST_CLEAR);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_index      = out_idx_r;
  assign out_ch.normal_x        = out_nx_r;
  assign out_ch.normal_y        = out_ny_r;
  assign out_ch.normal_z        = out_nz_r;
  assign out_ch.touching_faces  = out_tally_r;
  assign out_ch.no_faces        = out_none_r;
  assign out_ch.count_saturated = out_sat_r;

  assign sqrt_n    = sq_r;
  assign mul_p_nxt = mul_a * mul_b;
  assign ci        = cnt_r[1:0];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      emag[i] = mag33(e_r[i]);
    end
    any31 = 1'b0;
    any30 = 1'b0;
    for (int i = 0; i < 6; i++) begin
      any31 = any31 | (|emag[i][32:31]);
      any30 = any30 | (|emag[i][32:30]);
    end
  end

  // operands for the shared divider
  always_comb begin
    cmag_full = mag63(cr_r[ci]);
    cmag      = cmag_full[31:0];
    fnum = {cmag, 14'd0} + {15'd0, len_r[31:1]};
    case (ci)
      2'd0:    rsum = st_r.sx;
      2'd1:    rsum = st_r.sy;
      default: rsum = st_r.sz;
    endcase
    rmag = rsum[SUM_W-1] ? SUM_W'(-rsum) : SUM_W'(rsum);
    rnum = rmag + {{(SUM_W-TALLY_W+1){1'b0}}, st_r.tally[TALLY_W-1:1]};
    if (item_r.kind == KIND_FACE) begin
      div_req.rem_init = {2'd0, fnum[45:16]};
      div_req.den      = len_r;
      div_req.low      = {fnum[15:0], 8'd0};
      div_req.steps    = 5'd16;
      neg              = cr_r[ci][62];
    end else begin
      div_req.rem_init = '0;
      div_req.den      = {{(32-TALLY_W){1'b0}}, st_r.tally};
      div_req.low      = rnum;
      div_req.steps    = 5'(SUM_W);
      neg              = rsum[SUM_W-1];
    end
    q16 = neg ? NRM_W'(-div_quo[15:0]) : div_quo[15:0];
  end

  always_comb begin
    case (ci)
      2'd0:    corner = item_r.ca;
      2'd1:    corner = item_r.cb;
      default: corner = item_r.cc;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    pb_nxt        = pb_r;
    pa_nxt        = pa_r;
    e_nxt         = e_r;
    cr_nxt        = cr_r;
    u_nxt         = u_r;
    sq_nxt        = sq_r;
    len_nxt       = len_r;
    nrm_nxt       = nrm_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_nx_nxt    = out_nx_r;
    out_ny_nxt    = out_ny_r;
    out_nz_nxt    = out_nz_r;
    out_tally_nxt = out_tally_r;
    out_none_nxt  = out_none_r;
    out_sat_nxt   = out_sat_r;
    pos_we        = 1'b0;
    pos_waddr     = q_item.idx;
    pos_wdata     = {q_item.px, q_item.py, q_item.pz};
    pos_raddr     = q_item.cb;
    stat_we       = 1'b0;
    stat_waddr    = q_item.idx;
    stat_wdata    = '0;
    stat_raddr    = q_item.idx;
    mul_a         = '0;
    mul_b         = '0;
    pj            = '0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        stat_we    = 1'b1;
        stat_waddr = clr_r;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == IDX_W'(VERTEX_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (q_valid) begin
          item_nxt = q_item;
          cnt_nxt  = '0;
          case (q_item.kind)
            KIND_LOAD: begin
              pos_we  = 1'b1;
              stat_we = 1'b1;
            end
            KIND_FACE: state_nxt = ST_POS_B;
            KIND_READ: state_nxt = ST_STAT_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_STAT_RD: begin
        st_nxt = stat_q;
        if (stat_q.tally == '0) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = item_r.idx;
          out_nx_nxt    = '0;
          out_ny_nxt    = '0;
          out_nz_nxt    = '0;
          out_tally_nxt = '0;
          out_none_nxt  = 1'b1;
          out_sat_nxt   = stat_q.ovf;
          state_nxt     = ST_OUT;
        end else begin
          state_nxt = ST_DIV_GO;
        end
      end

      ST_POS_B: begin
        pb_nxt    = pos_q;
        pos_raddr = item_r.ca;
        state_nxt = ST_POS_A;
      end

      ST_POS_A: begin
        pa_nxt    = pos_q;
        pos_raddr = item_r.cc;
        state_nxt = ST_POS_C;
      end

      ST_POS_C: begin
        e_nxt[0]  = {pb_r.px[31], pb_r.px} - {pos_q.px[31], pos_q.px};
        e_nxt[1]  = {pb_r.py[31], pb_r.py} - {pos_q.py[31], pos_q.py};
        e_nxt[2]  = {pb_r.pz[31], pb_r.pz} - {pos_q.pz[31], pos_q.pz};
        e_nxt[3]  = {pb_r.px[31], pb_r.px} - {pa_r.px[31], pa_r.px};
        e_nxt[4]  = {pb_r.py[31], pb_r.py} - {pa_r.py[31], pa_r.py};
        e_nxt[5]  = {pb_r.pz[31], pb_r.pz} - {pa_r.pz[31], pa_r.pz};
        state_nxt = ST_SCALE;
      end

      ST_SCALE: begin
        // bring all edge components to a magnitude of at most 2^30
        for (int i = 0; i < 6; i++) begin
          if (any31) begin
            e_nxt[i] = e_r[i] >>> 2;
          end else if (any30) begin
            e_nxt[i] = e_r[i] >>> 1;
          end
        end
        cnt_nxt   = '0;
        state_nxt = ST_CROSS;
      end

      ST_CROSS: begin
        case (cnt_r)
          3'd0: begin mul_a = e_r[1]; mul_b = e_r[5]; end
          3'd1: begin mul_a = e_r[2]; mul_b = e_r[4]; end
          3'd2: begin mul_a = e_r[2]; mul_b = e_r[3]; end
          3'd3: begin mul_a = e_r[0]; mul_b = e_r[5]; end
          3'd4: begin mul_a = e_r[0]; mul_b = e_r[4]; end
          3'd5: begin mul_a = e_r[1]; mul_b = e_r[3]; end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        // fold in the product issued last cycle
        if (cnt_r != 3'd0) begin
          pj = 2'((cnt_r - 3'd1) >> 1);
          if (!cnt_r[0]) begin
            cr_nxt[pj] = cr_r[pj] - $signed(mul_p_r[62:0]);
          end else begin
            cr_nxt[pj] = $signed(mul_p_r[62:0]);
          end
        end
        if (cnt_r == 3'd6) begin
          cnt_nxt   = '0;
          state_nxt = ST_NORM_CHK;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_NORM_CHK: begin
        u_nxt   = mag63(cr_r[0]) | mag63(cr_r[1]) | mag63(cr_r[2]);
        cnt_nxt = '0;
        if (u_nxt == '0) begin
          for (int i = 0; i < 3; i++) begin
            nrm_nxt[i] = '0;
          end
          state_nxt = ST_ACC_RD;
        end else begin
          state_nxt = ST_NORM;
        end
      end

      ST_NORM: begin
        // one bit a cycle until the largest magnitude sits in [2^30, 2^31)
        if (|u_r[62:31]) begin
          u_nxt = u_r >> 1;
          for (int i = 0; i < 3; i++) begin
            cr_nxt[i] = cr_r[i] >>> 1;
          end
        end else if (!u_r[30]) begin
          u_nxt = u_r << 1;
          for (int i = 0; i < 3; i++) begin
            cr_nxt[i] = cr_r[i] <<< 1;
          end
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_SQ;
        end
      end

      ST_SQ: begin
        if (cnt_r != 3'd3) begin
          mul_a = $signed({1'b0, cmag});
          mul_b = $signed({1'b0, cmag});
        end
        if (cnt_r == 3'd1) begin
          sq_nxt = mul_p_r[63:0];
        end else if (cnt_r != 3'd0) begin
          sq_nxt = sq_r + mul_p_r[63:0];
        end
        if (cnt_r == 3'd3) begin
          state_nxt = ST_SQRT_GO;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_SQRT_GO: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_SQRT_WAIT;
      end

      ST_SQRT_WAIT: begin
        if (sqrt_done) begin
          len_nxt   = sqrt_root;
          cnt_nxt   = '0;
          state_nxt = ST_DIV_GO;
        end
      end

      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          nrm_nxt[ci] = q16;
          if (ci == 2'd2) begin
            cnt_nxt = '0;
            if (item_r.kind == KIND_FACE) begin
              state_nxt = ST_ACC_RD;
            end else begin
              out_valid_nxt = 1'b1;
              out_idx_nxt   = item_r.idx;
              out_nx_nxt    = nrm_r[0];
              out_ny_nxt    = nrm_r[1];
              out_nz_nxt    = q16;
              out_tally_nxt = st_r.tally;
              out_none_nxt  = 1'b0;
              out_sat_nxt   = st_r.ovf;
              state_nxt     = ST_OUT;
            end
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = ST_DIV_GO;
          end
        end
      end

      ST_ACC_RD: begin
        stat_raddr = corner;
        state_nxt  = ST_ACC_WR;
      end

      ST_ACC_WR: begin
        stat_we    = 1'b1;
        stat_waddr = corner;
        stat_wdata = stat_q;
        if (stat_q.tally >= TALLY_W'(MAX_FACES)) begin
          stat_wdata.ovf = 1'b1;
        end else begin
          stat_wdata.tally = stat_q.tally + 1'b1;
          stat_wdata.sx    = add_clamp(stat_q.sx, nrm_r[0]);
          stat_wdata.sy    = add_clamp(stat_q.sy, nrm_r[1]);
          stat_wdata.sz    = add_clamp(stat_q.sz, nrm_r[2]);
        end
        if (ci == 2'd2) begin
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_ACC_RD;
        end
      end

      ST_OUT: begin
        // hold the result until the sink takes it
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    pb_r        <= pb_nxt;
    pa_r        <= pa_nxt;
    e_r         <= e_nxt;
    mul_p_r     <= mul_p_nxt;
    cr_r        <= cr_nxt;
    u_r         <= u_nxt;
    sq_r        <= sq_nxt;
    len_r       <= len_nxt;
    nrm_r       <= nrm_nxt;
    st_r        <= st_nxt;
    out_idx_r   <= out_idx_nxt;
    out_nx_r    <= out_nx_nxt;
    out_ny_r    <= out_ny_nxt;
    out_nz_r    <= out_nz_nxt;
    out_tally_r <= out_tally_nxt;
    out_none_r  <= out_none_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_waddr] <= stat_wdata;
    end
    stat_q <= stat_mem[stat_raddr];
  end

  a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_OUT)
    else $error("result shown outside output state");

  a_sqrt_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_done |-> state_r == ST_SQRT_WAIT)
    else $error("square root finished with nobody waiting");

  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divide finished with nobody waiting");

  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && clr_r == IDX_W'(VERTEX_SLOTS - 1)) |=> state_r == ST_IDLE)
    else $error("clearing sweep did not finish");

endmodule

FILE: src/vertex_normal_averaging_unit.sv
// ----------------------------------------------------------------------------
// vertex_normal_averaging_unit
// Smooths triangle mesh vertex normals: loads positions, accumulates unit face
// normals per vertex, and returns averaged normals on request.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its 1024-entry normal-sum memory to zero with the
// input not ready. A read runs three 24-step divides, skipped when no face
// touched the vertex; a face runs the one-bit-per-cycle normalizing shift, the
// 32-step square root and three 16-step divides on the divider shared with
// reads, plus three read-modify-writes of the sum memory. A two-word queue
// takes new words while one is being worked on or while a result waits on the
// output.
module vertex_normal_averaging_unit import vna_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  vna_in_if.sink    in_ch,
  vna_out_if.source out_ch
);

  bk_stat_t    bk_stat;
  logic        q_valid;
  item_t       q_item;
  logic        div_start, div_done;
  div_req_t    div_req;
  logic [23:0] div_quo;
  logic        sqrt_start, sqrt_done;
  logic [63:0] sqrt_n;
  logic [31:0] sqrt_root;

  vna_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .bk_stat (bk_stat),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  vna_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  vna_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n_in  (sqrt_n),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  vna_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .bk_stat    (bk_stat),
    .out_ch     (out_ch),
    .div_start  (div_start),
    .div_req    (div_req),
    .div_done   (div_done),
    .div_quo    (div_quo),
    .sqrt_start (sqrt_start),
    .sqrt_n     (sqrt_n),
    .sqrt_done  (sqrt_done),
    .sqrt_root  (sqrt_root)
  );

endmodule

FILE: bench/vna_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_scoreboard
// Watches the word and result channels of the vertex normal averaging unit.
// It keeps its own copy of the vertex memories, predicts every read result,
// and compares each result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vna_scoreboard import vna_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  vna_in_if    in_ch,
  vna_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic [TALLY_W-1:0]      tally;
    logic                    empty;
    logic                    sat;
  } avg_normal_t;

  longint      vert_x [VERTEX_SLOTS];
  longint      vert_y [VERTEX_SLOTS];
  longint      vert_z [VERTEX_SLOTS];
  longint      acc_x  [VERTEX_SLOTS];
  longint      acc_y  [VERTEX_SLOTS];
  longint      acc_z  [VERTEX_SLOTS];
  int          faces_seen [VERTEX_SLOTS];
  bit          overflowed [VERTEX_SLOTS];
  avg_normal_t expected_normals [$];

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint div_round(longint num, longint den);
    longint q;
    q = (mag(num) + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r;
    bit [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic void unit_normal(input int a, input int b, input int c,
                                      output longint n [3]);
    longint    e [6];
    longint    cr [3];
    longint    m;
    int        k;
    bit [63:0] sq;
    bit [63:0] len;
    e[0] = vert_x[b] - vert_x[c];
    e[1] = vert_y[b] - vert_y[c];
    e[2] = vert_z[b] - vert_z[c];
    e[3] = vert_x[b] - vert_x[a];
    e[4] = vert_y[b] - vert_y[a];
    e[5] = vert_z[b] - vert_z[a];
    m = 0;
    foreach (e[i]) if (mag(e[i]) > m) m = mag(e[i]);
    k = 0;
    while ((m >>> k) >= (64'sd1 << 30)) k++;
    foreach (e[i]) e[i] = e[i] >>> k;
    cr[0] = e[1] * e[5] - e[2] * e[4];
    cr[1] = e[2] * e[3] - e[0] * e[5];
    cr[2] = e[0] * e[4] - e[1] * e[3];
    m = 0;
    foreach (cr[i]) if (mag(cr[i]) > m) m = mag(cr[i]);
    if (m == 0) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
      return;
    end
    k = 0;
    if (m >= (64'sd1 << 31)) begin
      while ((m >>> k) >= (64'sd1 << 31)) k++;
      foreach (cr[i]) cr[i] = cr[i] >>> k;
    end else begin
      while ((m << k) < (64'sd1 << 30)) k++;
      foreach (cr[i]) cr[i] = cr[i] <<< k;
    end
    sq = 0;
    foreach (cr[i]) sq = sq + 64'(mag(cr[i]) * mag(cr[i]));
    len = int_sqrt(sq);
    foreach (cr[i]) n[i] = div_round(cr[i] * 16384, longint'(len));
  endfunction

  function automatic void add_to_vertex(int v, longint n [3]);
    if (faces_seen[v] >= MAX_FACES) begin
      overflowed[v] = 1'b1;
      return;
    end
    faces_seen[v]++;
    acc_x[v] = clamp24(acc_x[v] + n[0]);
    acc_y[v] = clamp24(acc_y[v] + n[1]);
    acc_z[v] = clamp24(acc_z[v] + n[2]);
  endfunction

  always @(posedge clk) begin
    longint      n [3];
    int          v;
    avg_normal_t want;
    avg_normal_t got;
    if (!rst_n) begin
      foreach (vert_x[i]) begin
        vert_x[i] = 0; vert_y[i] = 0; vert_z[i] = 0;
        acc_x[i] = 0;  acc_y[i] = 0;  acc_z[i] = 0;
        faces_seen[i] = 0;
        overflowed[i] = 1'b0;
      end
      expected_normals.delete();
      fail_count = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        v = int'(in_ch.vertex_index);
        case (in_ch.mode)
          MODE_LOAD: begin
            vert_x[v] = longint'(in_ch.pos_x);
            vert_y[v] = longint'(in_ch.pos_y);
            vert_z[v] = longint'(in_ch.pos_z);
            acc_x[v] = 0; acc_y[v] = 0; acc_z[v] = 0;
            faces_seen[v] = 0;
            overflowed[v] = 1'b0;
          end
          MODE_FACE: begin
            unit_normal(int'(in_ch.corner_a), int'(in_ch.corner_b),
                        int'(in_ch.corner_c), n);
            add_to_vertex(int'(in_ch.corner_a), n);
            add_to_vertex(int'(in_ch.corner_b), n);
            add_to_vertex(int'(in_ch.corner_c), n);
          end
          MODE_READ: begin
            want.idx   = in_ch.vertex_index;
            want.tally = faces_seen[v][TALLY_W-1:0];
            want.empty = (faces_seen[v] == 0);
            want.sat   = overflowed[v];
            want.nx = '0; want.ny = '0; want.nz = '0;
            if (faces_seen[v] != 0) begin
              want.nx = NRM_W'(div_round(acc_x[v], longint'(faces_seen[v])));
              want.ny = NRM_W'(div_round(acc_y[v], longint'(faces_seen[v])));
              want.nz = NRM_W'(div_round(acc_z[v], longint'(faces_seen[v])));
            end
            expected_normals.push_back(want);
          end
          default: ;  // drop undefined mode
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.idx   = out_ch.read_index;
        got.nx    = out_ch.normal_x;
        got.ny    = out_ch.normal_y;
        got.nz    = out_ch.normal_z;
        got.tally = out_ch.touching_faces;
        got.empty = out_ch.no_faces;
        got.sat   = out_ch.count_saturated;
        if (expected_normals.size() == 0) begin
          $error("result word with nothing expected: read_index %0d", got.idx);
          fail_count++;
        end else begin
          want = expected_normals.pop_front();
          if (got.idx !== want.idx) begin
            $error("read_index: expected %0d, got %0d", want.idx, got.idx);
            fail_count++;
          end
          if (got.nx !== want.nx) begin
            $error("normal_x: expected %0d, got %0d", want.nx, got.nx);
            fail_count++;
          end
          if (got.ny !== want.ny) begin
            $error("normal_y: expected %0d, got %0d", want.ny, got.ny);
            fail_count++;
          end
          if (got.nz !== want.nz) begin
            $error("normal_z: expected %0d, got %0d", want.nz, got.nz);
            fail_count++;
          end
          if (got.tally !== want.tally) begin
            $error("touching_faces: expected %0d, got %0d", want.tally, got.tally);
            fail_count++;
          end
          if (got.empty !== want.empty) begin
            $error("no_faces: expected %0d, got %0d", want.empty, got.empty);
            fail_count++;
          end
          if (got.sat !== want.sat) begin
            $error("count_saturated: expected %0d, got %0d", want.sat, got.sat);
            fail_count++;
          end
        end
      end
    end
    pending <= expected_normals.size();
  end

endmodule

FILE: bench/vertex_normal_averaging_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_averaging_unit_tb
// Drives vertex loads, faces and reads into the normal averaging unit with
// random gaps and output stalls; a scoreboard beside the unit checks results.
// ----------------------------------------------------------------------------
module vertex_normal_averaging_unit_tb;
  import vna_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   words_sent;
  bit   no_gaps;
  int   mesh [$];
  int   stall_left;

  vna_in_if  in_ch ();
  vna_out_if out_ch ();

  vertex_normal_averaging_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vna_scoreboard checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side: mostly ready, short stalls, an occasional long one
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      stall_left   <= 0;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (!no_gaps && r < 25) begin
        out_ch.ready <= 1'b0;
        stall_left   <= (r < 3) ? $urandom_range(10, 80) : $urandom_range(0, 3);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic [1:0] m, int idx, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, int a, int b, int c);
    int g;
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= m;
    in_ch.vertex_index <= IDX_W'(idx);
    in_ch.pos_x        <= px;
    in_ch.pos_y        <= py;
    in_ch.pos_z        <= pz;
    in_ch.corner_a     <= IDX_W'(a);
    in_ch.corner_b     <= IDX_W'(b);
    in_ch.corner_c     <= IDX_W'(c);
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_vertex(int idx, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_word(MODE_LOAD, idx, px, py, pz, $urandom, $urandom, $urandom);
  endtask

  task automatic add_face(int a, int b, int c);
    send_word(MODE_FACE, $urandom, $urandom, $urandom, $urandom, a, b, c);
  endtask

  task automatic read_vertex(int idx);
    send_word(MODE_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0) return $urandom;
    if (r == 1) return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
    return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
  endfunction

  function automatic int pick_corner();
    return mesh[$urandom_range(0, mesh.size() - 1)];
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int hub;
    int a;
    int b;
    int c;
    int r;
    int n_faces;
    words_sent = 0;
    no_gaps = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= MODE_LOAD;
    in_ch.vertex_index <= '0;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.pos_z <= '0;
    in_ch.corner_a <= '0;
    in_ch.corner_b <= '0;
    in_ch.corner_c <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, degenerate faces, repeated corners, undefined mode
    read_vertex(7);
    load_vertex(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_vertex(1023, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    load_vertex(1, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
    load_vertex(2, 32'h0001_0000, 32'h0, 32'h0);
    load_vertex(3, 32'h0, 32'h0001_0000, 32'h0);
    load_vertex(4, 32'h0002_0000, 32'h0, 32'h0);
    load_vertex(5, 32'h0003_0000, 32'h0, 32'h0);
    add_face(0, 1023, 1);
    add_face(1, 2, 3);
    add_face(2, 4, 5);        // collinear corners
    add_face(2, 2, 3);        // repeated corner
    add_face(0, 1023, 0);
    send_word(2'd3, 9, $urandom, $urandom, $urandom, 1, 2, 3);
    read_vertex(0);
    read_vertex(1023);
    read_vertex(1);
    read_vertex(2);
    read_vertex(3);
    read_vertex(5);
    read_vertex(8);
    in_ch.valid <= 1'b0;
    wait_drained();

    // saturate one vertex's face count
    mesh.delete();
    for (int i = 10; i < 18; i++) begin
      load_vertex(i, rand_coord(), rand_coord(), rand_coord());
      mesh.push_back(i);
    end
    hub = 10;
    for (int i = 0; i < 300; i++) begin
      no_gaps = (i >= 100 && i < 140);
      add_face(hub, pick_corner(), pick_corner());
      if (i % 40 == 0) read_vertex(hub);
    end
    no_gaps = 0;
    read_vertex(hub);
    read_vertex(pick_corner());

    // hold the sender until every read has come back
    in_ch.valid <= 1'b0;
    wait_drained();

    // random meshes: load a handful of slots, add faces, read back
    while (words_sent < 1700) begin
      mesh.delete();
      no_gaps = ($urandom_range(0, 5) == 0);
      for (int i = $urandom_range(3, 9); i > 0; i--) begin
        b = $urandom_range(0, VERTEX_SLOTS - 1);
        load_vertex(b, rand_coord(), rand_coord(), rand_coord());
        mesh.push_back(b);
      end
      n_faces = $urandom_range(5, 50);
      for (int i = 0; i < n_faces; i++) begin
        r = $urandom_range(0, 99);
        a = pick_corner();
        b = pick_corner();
        c = pick_corner();
        if (r < 65) begin
          add_face(a, b, c);
        end else if (r < 90) begin
          read_vertex(pick_corner());
        end else if (r < 94) begin
          read_vertex($urandom_range(0, VERTEX_SLOTS - 1));
        end else if (r < 97) begin
          send_word(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        end else begin
          // reload a mesh slot mid-sequence
          load_vertex(a, rand_coord(), rand_coord(), rand_coord());
        end
      end
      foreach (mesh[i]) if ($urandom_range(0, 1)) read_vertex(mesh[i]);
    end
    in_ch.valid <= 1'b0;
    no_gaps = 1;

    wait_drained();
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: vertex_normal_averaging_unit.f
src/vna_pkg.sv
src/vna_in_if.sv
src/vna_out_if.sv
src/vna_front.sv
src/vna_div.sv
src/vna_isqrt.sv
src/vna_back.sv
src/vertex_normal_averaging_unit.sv
bench/vna_scoreboard.sv
bench/vertex_normal_averaging_unit_tb.sv
